@@ src/lcd4_pkg.sv @@
// lcd4_pkg: shared types, constants and nibble lookup for the 4-bit LCD sequencer.
// No dependencies; compiled first.
package lcd4_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] HOLD_MAX            = 16'hFFFF;
  localparam logic [15:0] POWER_UP_WAIT_RESET = 16'd40000;
  localparam logic [15:0] WAKE_WAIT_RESET     = 16'd200;
  localparam logic [15:0] PULSE_RESET         = 16'd5;
  localparam logic [15:0] COMMAND_WAIT_RESET  = 16'd40;
  localparam logic [15:0] CLEAR_WAIT_RESET    = 16'd2000;

  localparam logic [3:0] WAKE_NIB   = 4'h3;
  localparam logic [3:0] MODE_NIB   = 4'h2;
  localparam logic [7:0] CLEAR_BYTE = 8'h01;
  localparam logic [7:0] HOME_BYTE  = 8'h02;

  // nibble positions inside a run
  localparam logic [3:0] INIT_WAKE_NIBS = 4'd3;   // nibbles 0..2 are wake nibbles
  localparam logic [3:0] INIT_MODE_NIB  = 4'd3;
  localparam logic [3:0] INIT_BYTE_NIB0 = 4'd4;   // first byte nibble of init
  localparam logic [3:0] INIT_CLEAR_NIB = 4'd9;   // low nibble of the clear byte
  localparam logic [3:0] INIT_LAST_NIB  = 4'd13;
  localparam logic [3:0] BYTE_LAST_NIB  = 4'd1;

  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_INSTR = 3'd1,
    CMD_CHAR  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_HOME  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_POWER_UP_WAIT = 3'd0,
    REG_WAKE_WAIT     = 3'd1,
    REG_PULSE         = 3'd2,
    REG_COMMAND_WAIT  = 3'd3,
    REG_CLEAR_WAIT    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_NIB,
    ST_POST
  } state_e;

  typedef enum logic [1:0] {
    PH_SETUP,
    PH_HIGH,
    PH_LOW
  } phase_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [15:0] power_up_wait_us;
    logic [15:0] wake_wait_us;
    logic [15:0] pulse_us;
    logic [15:0] command_wait_us;
    logic [15:0] clear_wait_us;
  } cfg_t;

  // queue link between front and back
  typedef struct packed {
    logic valid;
    req_t req;
  } qlink_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = CLEAR_BYTE;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h0C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // data nibble driven during nibble n of a run
  function automatic logic [3:0] nib_value(input cmd_e cmd, input logic [7:0] val,
                                           input logic [3:0] n);
    logic [7:0] b;
    logic [3:0] k;
    logic       hi;
    k  = n - INIT_BYTE_NIB0;
    b  = val;
    hi = ~n[0];
    unique case (cmd) inside
      CMD_INIT: begin
        b  = init_byte(k[3:1]);
        hi = ~k[0];
      end
      CMD_INSTR, CMD_CHAR: b = val;
      CMD_CLEAR:           b = CLEAR_BYTE;
      CMD_HOME:            b = HOME_BYTE;
      default:             b = val;
    endcase
    if (cmd == CMD_INIT && n < INIT_WAKE_NIBS) begin
      return WAKE_NIB;
    end else if (cmd == CMD_INIT && n == INIT_MODE_NIB) begin
      return MODE_NIB;
    end
    return hi ? b[7:4] : b[3:0];
  endfunction

endpackage

@@ src/lcd4_if.sv @@
// lcd4_if: valid/ready channel interfaces for requests, segments and register writes.
// Depends on lcd4_pkg.
interface lcd4_req_if import lcd4_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface lcd4_seg_if import lcd4_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        rs;
  logic        enable;
  logic [3:0]  data_nibble;
  logic [15:0] hold_us;
  logic        last;
  modport source (output valid, rs, enable, data_nibble, hold_us, last, input ready);
  modport sink   (input valid, rs, enable, data_nibble, hold_us, last, output ready);
endinterface

interface lcd4_cfg_if import lcd4_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/lcd4_front.sv @@
// lcd4_front: accepts request beats, drops unknown commands, queues the rest.
// Depends on lcd4_pkg and lcd4_if.
module lcd4_front import lcd4_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcd4_req_if.sink    req_i,
  output qlink_t      q_o,
  input  logic        q_ready_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  req_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            known, push, pop;

  always_comb begin
    unique case (req_i.cmd) inside
      CMD_INIT, CMD_INSTR, CMD_CHAR, CMD_CLEAR, CMD_HOME: known = 1'b1;
      default:                                            known = 1'b0;
    endcase
  end

  assign req_i.ready = (cnt_q != CntW'(QueueDepth));
  assign push        = req_i.valid && req_i.ready && known;
  assign q_o.valid   = (cnt_q != '0);
  assign q_o.req     = mem_q[rd_ptr_q];
  assign pop         = q_o.valid && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cmd: cmd_e'(req_i.cmd), value: req_i.value};
    end
  end

endmodule

@@ src/lcd4_back.sv @@
// lcd4_back: walks one request as a run of pin-state segments into an output register.
// Depends on lcd4_pkg and lcd4_if.
module lcd4_back import lcd4_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  qlink_t     q_i,
  output logic       q_ready_o,
  lcd4_seg_if.source seg_o
);

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  cmd_e        cmd_q, cmd_d;
  logic [7:0]  val_q, val_d;
  logic [3:0]  data_q, data_d;

  logic        ovld_q, ovld_d;
  logic        ors_q, oen_q, olast_q;
  logic [3:0]  onib_q;
  logic [15:0] ohold_q;

  logic        is_init, is_char, byte_end, clr_end;
  logic [3:0]  last_nib, nib_v;
  logic        seg_valid, seg_rs, seg_en, seg_last, load, take;
  logic [3:0]  seg_nib;
  logic [15:0] t0, t1, t2, seg_hold;
  logic [17:0] hold_sum;

  assign is_init  = (cmd_q == CMD_INIT);
  assign is_char  = (cmd_q == CMD_CHAR);
  assign last_nib = is_init ? INIT_LAST_NIB : BYTE_LAST_NIB;
  assign nib_v    = nib_value(cmd_q, val_q, nib_q);
  assign byte_end = is_init ? (nib_q >= INIT_BYTE_NIB0 && nib_q[0]) : (nib_q == BYTE_LAST_NIB);
  assign clr_end  = is_init ? (nib_q == INIT_CLEAR_NIB)
                            : ((cmd_q == CMD_CLEAR || cmd_q == CMD_HOME) &&
                               nib_q == BYTE_LAST_NIB);

  // segment for the current position
  always_comb begin
    seg_rs   = 1'b0;
    seg_en   = 1'b0;
    seg_nib  = data_q;
    seg_last = 1'b0;
    t0       = '0;
    t1       = '0;
    t2       = '0;
    unique case (state_q)
      ST_IDLE: ;
      ST_PRE: begin
        seg_rs = is_char;
        t0     = is_init ? cfg_i.power_up_wait_us : cfg_i.pulse_us;
      end
      ST_NIB: begin
        seg_rs  = is_char;
        seg_en  = (phase_q == PH_HIGH);
        seg_nib = nib_v;
        t0      = cfg_i.pulse_us;
        if (phase_q == PH_LOW) begin
          if (is_init && nib_q < INIT_WAKE_NIBS) t1 = cfg_i.wake_wait_us;
          if (byte_end) t1 = cfg_i.command_wait_us;
          if (clr_end)  t2 = cfg_i.clear_wait_us;
          seg_last = (nib_q == last_nib) && !is_char;
        end
      end
      ST_POST: begin
        t0       = cfg_i.command_wait_us;
        seg_last = 1'b1;
      end
      default: ;
    endcase
  end

  // three-term hold sum, saturated to 16 bits
  assign hold_sum = {2'b00, t0} + {2'b00, t1} + {2'b00, t2};
  assign seg_hold = (hold_sum[17:16] != 2'b00) ? HOLD_MAX : hold_sum[15:0];

  assign seg_valid = (state_q != ST_IDLE);
  assign load      = seg_valid && (!ovld_q || seg_o.ready);
  // next request is taken as the current run hands over its last segment
  assign take      = (state_q == ST_IDLE) || (load && seg_last);
  assign q_ready_o = take;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    nib_d   = nib_q;
    cmd_d   = cmd_q;
    val_d   = val_q;
    data_d  = data_q;
    if (load) begin
      unique case (state_q)
        ST_PRE: begin
          state_d = ST_NIB;
          nib_d   = '0;
          phase_d = PH_SETUP;
        end
        ST_NIB: begin
          data_d = nib_v;
          unique case (phase_q)
            PH_SETUP: phase_d = PH_HIGH;
            PH_HIGH:  phase_d = PH_LOW;
            default: begin
              phase_d = PH_SETUP;
              if (nib_q == last_nib) begin
                state_d = is_char ? ST_POST : ST_IDLE;
              end else begin
                nib_d = nib_q + 1'b1;
              end
            end
          endcase
        end
        ST_POST: state_d = ST_IDLE;
        default: state_d = ST_IDLE;
      endcase
    end
    if (take && q_i.valid) begin
      cmd_d   = q_i.req.cmd;
      val_d   = q_i.req.value;
      nib_d   = '0;
      phase_d = PH_SETUP;
      state_d = (q_i.req.cmd == CMD_INIT || q_i.req.cmd == CMD_CHAR) ? ST_PRE : ST_NIB;
    end
  end

  always_comb begin
    ovld_d = ovld_q;
    if (load) begin
      ovld_d = 1'b1;
    end else if (seg_o.ready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_SETUP;
      nib_q   <= '0;
      data_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      nib_q   <= nib_d;
      data_q  <= data_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    val_q <= val_d;
    if (load) begin
      ors_q   <= seg_rs;
      oen_q   <= seg_en;
      onib_q  <= seg_nib;
      ohold_q <= seg_hold;
      olast_q <= seg_last;
    end
  end

  assign seg_o.valid       = ovld_q;
  assign seg_o.rs          = ors_q;
  assign seg_o.enable      = oen_q;
  assign seg_o.data_nibble = onib_q;
  assign seg_o.hold_us     = ohold_q;
  assign seg_o.last        = olast_q;

endmodule

@@ src/char_lcd_4bit_sequencer.sv @@
// char_lcd_4bit_sequencer: top level; register file, request front and segment back.
// Depends on lcd4_pkg, lcd4_if, lcd4_front and lcd4_back.
//
//   channel  dir  beat carries                               accepted when
//   req_i    in   cmd[2:0], value[7:0]                       valid && ready
//   seg_o    out  rs, enable, data_nibble[3:0], hold_us, last valid && ready
//   cfg_i    in   index[2:0], data[15:0]                     valid && ready (ready tied high)
//
// One segment per cycle unless seg_o stalls: a run is 6 (instruction, clear, home), 8 (character)
// or 43 (init) segments, set by the back sequencer; the next queued request starts right behind it.
// A request reaching an idle back is registered there first. Unknown commands are taken and dropped.
// Reset restores register defaults and clears the queue; no clearing pass.
// A stall on seg_o holds the output register; the front keeps taking requests until its queue fills.
module char_lcd_4bit_sequencer import lcd4_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcd4_req_if.sink   req_i,
  lcd4_cfg_if.sink   cfg_i,
  lcd4_seg_if.source seg_o
);

  cfg_t   cfg_q;
  qlink_t q_link;
  logic   q_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_up_wait_us <= POWER_UP_WAIT_RESET;
      cfg_q.wake_wait_us     <= WAKE_WAIT_RESET;
      cfg_q.pulse_us         <= PULSE_RESET;
      cfg_q.command_wait_us  <= COMMAND_WAIT_RESET;
      cfg_q.clear_wait_us    <= CLEAR_WAIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_POWER_UP_WAIT: cfg_q.power_up_wait_us <= cfg_i.data;
        REG_WAKE_WAIT:     cfg_q.wake_wait_us     <= cfg_i.data;
        REG_PULSE:         cfg_q.pulse_us         <= cfg_i.data;
        REG_COMMAND_WAIT:  cfg_q.command_wait_us  <= cfg_i.data;
        REG_CLEAR_WAIT:    cfg_q.clear_wait_us    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  lcd4_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_o       (q_link),
    .q_ready_i (q_ready)
  );

  lcd4_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_i       (q_link),
    .q_ready_o (q_ready),
    .seg_o     (seg_o)
  );

  // an enable pulse never ends a run
  a_en_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid && seg_o.enable |-> !seg_o.last)
    else $error("enable-high segment flagged last");

  // every run leaves RS low
  a_last_rs_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid && seg_o.last |-> !seg_o.rs)
    else $error("run ended with RS high");

  // enable high is followed by enable low on the same nibble
  a_pulse_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid && seg_o.ready && seg_o.enable |=>
      seg_o.valid && !seg_o.enable && seg_o.data_nibble == $past(seg_o.data_nibble))
    else $error("enable pulse not closed on the same nibble");

  // a request taken while the output is stalled leaves the output segment valid
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready && q_link.valid |=> seg_o.valid || !$past(seg_o.valid) || $past(seg_o.ready))
    else $error("request taken while output stalled");

endmodule
